### rtl/gfcm_pkg.sv
// Package for the gated frequency and capacitance meter.
// Holds widths, reset values, register indexes and the gate record type.
// Used by every other file of the block; depends on nothing.
package gfcm_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned TICK_WIDTH = 16;
  localparam int unsigned FREQ_WIDTH = 24;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned CFG_INDEX_WIDTH = 8;

  // Queue depth must be a power of two so that the pointers wrap naturally.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_WIDTH = $clog2(QUEUE_DEPTH);

  localparam logic [TICK_WIDTH-1:0] GATE_RESET = 16'd2000;
  localparam logic [WORD_WIDTH-1:0] CAP_RESET = 32'd283076923;
  localparam logic [WORD_WIDTH-1:0] NS_PER_SECOND = 32'd1000000000;
  localparam logic [FREQ_WIDTH-1:0] FREQ_MAX = '1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GATE_TICKS = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAP_CONSTANT = 8'd1;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] seconds;
    logic                  overflow;
    logic [FREQ_WIDTH-1:0] freq;
  } gate_rec_t;

endpackage

### rtl/gfcm_if.sv
// Channel interfaces of the gated frequency and capacitance meter.
// Sample input, result output and configuration write channel.
// Depends on gfcm_pkg for the field widths.
interface gfcm_sample_if;
  logic valid;
  logic ready;
  logic edge_seen;
  logic tick;

  modport source (output valid, output edge_seen, output tick, input ready);
  modport sink (input valid, input edge_seen, input tick, output ready);
endinterface

interface gfcm_result_if;
  logic                            valid;
  logic                            ready;
  logic [gfcm_pkg::FREQ_WIDTH-1:0] frequency;
  logic [gfcm_pkg::WORD_WIDTH-1:0] capacitance_pf;
  logic [gfcm_pkg::WORD_WIDTH-1:0] period_ns;
  logic [gfcm_pkg::WORD_WIDTH-1:0] seconds_elapsed;
  logic                            count_overflow;
  logic                            no_signal;

  modport source (output valid, output frequency, output capacitance_pf, output period_ns,
                  output seconds_elapsed, output count_overflow, output no_signal,
                  input ready);
  modport sink (input valid, input frequency, input capacitance_pf, input period_ns,
                input seconds_elapsed, input count_overflow, input no_signal,
                output ready);
endinterface

interface gfcm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [gfcm_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [gfcm_pkg::WORD_WIDTH-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/gated_frequency_capacitance_meter.sv
// Gated frequency and capacitance meter, top level.
// Takes one sample transfer per cycle; the input stalls only while the gate queue is full.
// A result becomes valid once the record of the gate that the sample closed has left the queue
// and run the 32 steps of the radix-2 divider, or once it has left the queue when no edge was seen.
// The back end takes a new gate record only after the current result has been taken.
// Reset clears all counters and the queue and loads the default gate length and constant.
module gated_frequency_capacitance_meter #(
  parameter int unsigned COUNT_WIDTH = gfcm_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gfcm_sample_if.sink   sample_i,
  gfcm_result_if.source result_o,
  gfcm_cfg_if.sink      cfg_i
);

  logic [gfcm_pkg::TICK_WIDTH-1:0] gate_ticks_q;
  logic [gfcm_pkg::WORD_WIDTH-1:0] cap_constant_q;
  logic                            push, pop, full, empty;
  gfcm_pkg::gate_rec_t             rec, head;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_ticks_q <= gfcm_pkg::GATE_RESET;
      cap_constant_q <= gfcm_pkg::CAP_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        gfcm_pkg::CFG_GATE_TICKS: begin
          gate_ticks_q <= cfg_i.data[gfcm_pkg::TICK_WIDTH-1:0];
        end
        gfcm_pkg::CFG_CAP_CONSTANT: begin
          cap_constant_q <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  gfcm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .gate_ticks_i(gate_ticks_q),
    .full_i      (full),
    .push_o      (push),
    .rec_o       (rec)
  );

  gfcm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  gfcm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_constant_i(cap_constant_q),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .result_o      (result_o)
  );

  a_nosig_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.no_signal == (result_o.frequency == '0)))
    else $error("no_signal disagrees with frequency");

  a_nosig_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.no_signal |->
      (result_o.capacitance_pf == '1) && (result_o.period_ns == '1))
    else $error("quotients not forced to all ones without signal");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.no_signal |-> result_o.period_ns <= gfcm_pkg::NS_PER_SECOND)
    else $error("period exceeds one second");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("gate record pushed into a full queue");

endmodule

### rtl/gfcm_front.sv
// Front end: counts edges and ticks per sample and closes the gate.
// Pushes one gate record into the queue for every gate that closes.
// Depends on gfcm_pkg and gfcm_sample_if.
module gfcm_front #(
  parameter int unsigned COUNT_WIDTH = gfcm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gfcm_sample_if.sink                       sample_i,
  input  logic [gfcm_pkg::TICK_WIDTH-1:0]   gate_ticks_i,
  input  logic                              full_i,
  output logic                              push_o,
  output gfcm_pkg::gate_rec_t               rec_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [gfcm_pkg::TICK_WIDTH-1:0] tick_cnt_q, tick_cnt_d;
  logic [COUNT_WIDTH-1:0]          edge_cnt_q, edge_cnt_d, edge_new;
  logic                            sat_q, sat_d, sat_new;
  logic [gfcm_pkg::WORD_WIDTH-1:0] gate_cnt_q, gate_cnt_d;
  logic [gfcm_pkg::TICK_WIDTH:0]   tick_next;
  logic [32:0]                     edge_wide;
  logic                            above;
  logic                            accept;

  assign sample_i.ready = !full_i;
  assign accept = sample_i.valid && sample_i.ready;

  always_comb begin
    edge_new = edge_cnt_q;
    sat_new = sat_q;
    if (sample_i.edge_seen) begin
      if (edge_cnt_q == CountMax) begin
        sat_new = 1'b1;
      end else begin
        edge_new = edge_cnt_q + 1'b1;
      end
    end
    edge_wide = 33'(edge_new);
    above = edge_wide > 33'(gfcm_pkg::FREQ_MAX);
    tick_next = {1'b0, tick_cnt_q} + 1'b1;

    rec_o.freq = above ? gfcm_pkg::FREQ_MAX : edge_wide[gfcm_pkg::FREQ_WIDTH-1:0];
    rec_o.overflow = sat_new || above;
    rec_o.seconds = gate_cnt_q + 1'b1;

    tick_cnt_d = tick_cnt_q;
    edge_cnt_d = edge_cnt_q;
    sat_d = sat_q;
    gate_cnt_d = gate_cnt_q;
    push_o = 1'b0;
    if (accept) begin
      edge_cnt_d = edge_new;
      sat_d = sat_new;
      if (sample_i.tick) begin
        if (tick_next < {1'b0, gate_ticks_i}) begin
          tick_cnt_d = tick_next[gfcm_pkg::TICK_WIDTH-1:0];
        end else begin
          push_o = 1'b1;
          gate_cnt_d = rec_o.seconds;
          tick_cnt_d = '0;
          edge_cnt_d = '0;
          sat_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= '0;
      edge_cnt_q <= '0;
      sat_q <= 1'b0;
      gate_cnt_q <= '0;
    end else begin
      tick_cnt_q <= tick_cnt_d;
      edge_cnt_q <= edge_cnt_d;
      sat_q <= sat_d;
      gate_cnt_q <= gate_cnt_d;
    end
  end

endmodule

### rtl/gfcm_queue.sv
// Short queue of gate records between the front end and the divider.
// Registered entries, one write and one read port.
// Depends on gfcm_pkg.
module gfcm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gfcm_pkg::gate_rec_t rec_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output gfcm_pkg::gate_rec_t head_o
);

  gfcm_pkg::gate_rec_t mem_q [gfcm_pkg::QUEUE_DEPTH];

  logic [gfcm_pkg::QPTR_WIDTH-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [gfcm_pkg::QPTR_WIDTH:0]   cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o = cnt_q == (gfcm_pkg::QPTR_WIDTH + 1)'(gfcm_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

### rtl/gfcm_back.sv
// Back end: takes gate records and works out both quotients.
// Two radix-2 restoring dividers share one step counter; the result registers drive the output.
// Depends on gfcm_pkg and gfcm_result_if.
module gfcm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [gfcm_pkg::WORD_WIDTH-1:0] cap_constant_i,
  input  logic                            empty_i,
  input  gfcm_pkg::gate_rec_t             head_i,
  output logic                            pop_o,
  gfcm_result_if.source                   result_o
);

  localparam int unsigned FW = gfcm_pkg::FREQ_WIDTH;
  localparam int unsigned WW = gfcm_pkg::WORD_WIDTH;
  localparam int unsigned StepWidth = $clog2(WW);

  typedef enum logic [2:0] {
    BACK_IDLE = 3'b001,
    BACK_DIV  = 3'b010,
    BACK_DONE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [StepWidth-1:0] step_q, step_d;
  logic [FW-1:0]        divisor_q, divisor_d;
  logic [FW-1:0]        a_rem_q, a_rem_d, b_rem_q, b_rem_d;
  logic [WW-1:0]        a_quo_q, a_quo_d, b_quo_q, b_quo_d;
  logic [FW-1:0]        freq_q, freq_d;
  logic [WW-1:0]        secs_q, secs_d;
  logic                 ovf_q, ovf_d, nosig_q, nosig_d;
  logic [FW+WW-1:0]     a_next, b_next;

  function automatic logic [FW+WW-1:0] div_step(input logic [FW-1:0] rem,
                                                input logic [WW-1:0] quo,
                                                input logic [FW-1:0] div);
    logic [FW:0]   sh;
    logic [FW:0]   diff;
    logic          ge;
    logic [FW-1:0] rem_n;
    sh = {rem, quo[WW-1]};
    diff = sh - {1'b0, div};
    ge = sh >= {1'b0, div};
    rem_n = ge ? diff[FW-1:0] : sh[FW-1:0];
    return {rem_n, quo[WW-2:0], ge};
  endfunction

  assign a_next = div_step(a_rem_q, a_quo_q, divisor_q);
  assign b_next = div_step(b_rem_q, b_quo_q, divisor_q);

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    divisor_d = divisor_q;
    a_rem_d = a_rem_q;
    a_quo_d = a_quo_q;
    b_rem_d = b_rem_q;
    b_quo_d = b_quo_q;
    freq_d = freq_q;
    secs_d = secs_q;
    ovf_d = ovf_q;
    nosig_d = nosig_q;
    pop_o = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          freq_d = head_i.freq;
          secs_d = head_i.seconds;
          ovf_d = head_i.overflow;
          divisor_d = head_i.freq;
          a_rem_d = '0;
          b_rem_d = '0;
          step_d = '0;
          if (head_i.freq == '0) begin
            nosig_d = 1'b1;
            a_quo_d = '1;
            b_quo_d = '1;
            state_d = BACK_DONE;
          end else begin
            nosig_d = 1'b0;
            a_quo_d = cap_constant_i;
            b_quo_d = gfcm_pkg::NS_PER_SECOND;
            state_d = BACK_DIV;
          end
        end
      end
      BACK_DIV: begin
        {a_rem_d, a_quo_d} = a_next;
        {b_rem_d, b_quo_d} = b_next;
        step_d = step_q + 1'b1;
        if (step_q == StepWidth'(WW - 1)) begin
          state_d = BACK_DONE;
        end
      end
      BACK_DONE: begin
        if (result_o.ready) begin
          state_d = BACK_IDLE;
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    a_rem_q <= a_rem_d;
    a_quo_q <= a_quo_d;
    b_rem_q <= b_rem_d;
    b_quo_q <= b_quo_d;
    freq_q <= freq_d;
    secs_q <= secs_d;
    ovf_q <= ovf_d;
    nosig_q <= nosig_d;
  end

  assign result_o.valid = state_q == BACK_DONE;
  assign result_o.frequency = freq_q;
  assign result_o.capacitance_pf = a_quo_q;
  assign result_o.period_ns = b_quo_q;
  assign result_o.seconds_elapsed = secs_q;
  assign result_o.count_overflow = ovf_q;
  assign result_o.no_signal = nosig_q;

endmodule

### dv/tb_gated_frequency_capacitance_meter.sv
// Self-checking testbench for the gated frequency and capacitance meter.
// Predicts every gate reading from the sample stream and compares each result transfer.
// Depends on gfcm_pkg, the channel interfaces and the top level of the block.
`timescale 1ns / 100ps

module tb_gated_frequency_capacitance_meter;

  localparam int unsigned COUNT_W = gfcm_pkg::COUNT_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 220;
  localparam int unsigned DEFAULT_PROBE_TICKS = 100;
  localparam int unsigned LONG_PROBE_TICKS = 40;
  localparam logic [gfcm_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LOW = 8'd2;
  localparam logic [gfcm_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_TOP = 8'hFF;

  typedef struct packed {
    logic [gfcm_pkg::FREQ_WIDTH-1:0] frequency;
    logic [gfcm_pkg::WORD_WIDTH-1:0] capacitance_pf;
    logic [gfcm_pkg::WORD_WIDTH-1:0] period_ns;
    logic [gfcm_pkg::WORD_WIDTH-1:0] seconds_elapsed;
    logic                            count_overflow;
    logic                            no_signal;
  } gate_reading_t;

  logic clk_i;
  logic rst_ni;

  gfcm_sample_if sample_ch ();
  gfcm_result_if result_ch ();
  gfcm_cfg_if    cfg_ch ();

  gated_frequency_capacitance_meter #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  // Predicted block state and register copies.
  logic [gfcm_pkg::TICK_WIDTH-1:0] gate_len = gfcm_pkg::GATE_RESET;
  logic [gfcm_pkg::WORD_WIDTH-1:0] cap_const = gfcm_pkg::CAP_RESET;
  logic [gfcm_pkg::TICK_WIDTH-1:0] ticks_in_gate = '0;
  logic [COUNT_W-1:0]              edges_in_gate = '0;
  bit                              edges_clipped = 1'b0;
  logic [gfcm_pkg::WORD_WIDTH-1:0] gates_closed = '0;

  gate_reading_t pending_readings[$];
  int unsigned   mismatches = 0;
  bit            steady = 1'b0;
  bit            holdoff_req = 1'b0;
  int unsigned   idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_sample(input bit has_edge, input bit has_tick);
    logic [gfcm_pkg::TICK_WIDTH:0]   next_ticks;
    logic [gfcm_pkg::FREQ_WIDTH-1:0] freq;
    logic                            clipped;
    gate_reading_t                   rd;
    if (has_edge) begin
      if (edges_in_gate == '1) begin
        edges_clipped = 1'b1;
      end else begin
        edges_in_gate = edges_in_gate + 1'b1;
      end
    end
    if (!has_tick) begin
      return;
    end
    next_ticks = {1'b0, ticks_in_gate} + 1'b1;
    if (next_ticks < {1'b0, gate_len}) begin
      ticks_in_gate = next_ticks[gfcm_pkg::TICK_WIDTH-1:0];
      return;
    end
    clipped = edges_clipped;
    if (64'(edges_in_gate) > 64'(gfcm_pkg::FREQ_MAX)) begin
      freq = gfcm_pkg::FREQ_MAX;
      clipped = 1'b1;
    end else begin
      freq = gfcm_pkg::FREQ_WIDTH'(edges_in_gate);
    end
    gates_closed = gates_closed + 1'b1;
    rd.frequency = freq;
    rd.seconds_elapsed = gates_closed;
    rd.count_overflow = clipped;
    if (freq == '0) begin
      rd.capacitance_pf = '1;
      rd.period_ns = '1;
      rd.no_signal = 1'b1;
    end else begin
      rd.capacitance_pf = cap_const / gfcm_pkg::WORD_WIDTH'(freq);
      rd.period_ns = gfcm_pkg::NS_PER_SECOND / gfcm_pkg::WORD_WIDTH'(freq);
      rd.no_signal = 1'b0;
    end
    pending_readings.push_back(rd);
    ticks_in_gate = '0;
    edges_in_gate = '0;
    edges_clipped = 1'b0;
  endfunction

  function automatic void apply_register_write(
      input logic [gfcm_pkg::CFG_INDEX_WIDTH-1:0] idx,
      input logic [gfcm_pkg::WORD_WIDTH-1:0] data);
    case (idx)
      gfcm_pkg::CFG_GATE_TICKS: begin
        gate_len = data[gfcm_pkg::TICK_WIDTH-1:0];
      end
      gfcm_pkg::CFG_CAP_CONSTANT: begin
        cap_const = data;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // All tasks below start and end at a falling edge.
  task automatic send_sample(input bit has_edge, input bit has_tick);
    while (!steady && $urandom_range(99) < 9) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.edge_seen <= has_edge;
    sample_ch.tick <= has_tick;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    predict_sample(has_edge, has_tick);
    @(negedge clk_i);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [gfcm_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [gfcm_pkg::WORD_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    apply_register_write(idx, data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // The default gate must stay open; shortening it then closes it on the next tick.
  task automatic test_default_gate();
    repeat (DEFAULT_PROBE_TICKS) send_sample(1'($urandom_range(1)), 1'b1);
    settle();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd50);
    send_sample(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_directed_cases();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd2);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b1);
    settle();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    settle();
    write_reg(gfcm_pkg::CFG_CAP_CONSTANT, '0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    settle();
    write_reg(gfcm_pkg::CFG_CAP_CONSTANT, '1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    settle();
    write_reg(CFG_UNUSED_LOW, '1);
    write_reg(CFG_UNUSED_TOP, 32'd7);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    settle();
  endtask

  task automatic test_gate_length_extremes();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, '0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    settle();
    // Count ticks into a longer gate, then shorten the gate below the ticks already counted.
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd10);
    repeat (5) send_sample(1'($urandom_range(1)), 1'b1);
    settle();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd3);
    send_sample(1'b1, 1'b1);
    repeat (3) send_sample(1'b1, 1'b1);
    settle();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd65535);
    repeat (LONG_PROBE_TICKS) send_sample(1'($urandom_range(1)), 1'b1);
    settle();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'(LONG_PROBE_TICKS));
    send_sample(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_result_backpressure();
    write_reg(gfcm_pkg::CFG_GATE_TICKS, 32'd1);
    holdoff_req = 1'b1;
    repeat (40) send_sample(1'($urandom_range(1)), 1'b1);
    settle();
  endtask

  task automatic test_random_gates();
    int unsigned edge_pct;
    int unsigned tick_pct;
    logic [gfcm_pkg::WORD_WIDTH-1:0] cap_val;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(4))
        0: edge_pct = 0;
        1: edge_pct = 10;
        2: edge_pct = 90;
        3: edge_pct = 100;
        default: edge_pct = 50;
      endcase
      tick_pct = $urandom_range(100, 20);
      case (phase % 4)
        0: cap_val = '0;
        1: cap_val = '1;
        default: cap_val = $urandom;
      endcase
      write_reg(gfcm_pkg::CFG_GATE_TICKS, gfcm_pkg::WORD_WIDTH'($urandom_range(6)));
      write_reg(gfcm_pkg::CFG_CAP_CONSTANT, cap_val);
      steady = (phase == 3);
      repeat (PHASE_ITEMS) begin
        send_sample($urandom_range(99) < edge_pct, $urandom_range(99) < tick_pct);
      end
      steady = 1'b0;
      settle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.edge_seen = 1'b0;
    sample_ch.tick = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_gate();
    test_directed_cases();
    test_gate_length_extremes();
    test_result_backpressure();
    test_random_gates();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
      end
      result_ch.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    gate_reading_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no gate reading pending");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        check_field("frequency", want.frequency, result_ch.frequency);
        check_field("capacitance_pf", want.capacitance_pf, result_ch.capacitance_pf);
        check_field("period_ns", want.period_ns, result_ch.period_ns);
        check_field("seconds_elapsed", want.seconds_elapsed, result_ch.seconds_elapsed);
        check_field("count_overflow", want.count_overflow, result_ch.count_overflow);
        check_field("no_signal", want.no_signal, result_ch.no_signal);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
